// ===== sv/irn_pkg.sv =====
// shared types, constants and symbol tables for the integer to roman numeral unit
package irn_pkg;

   localparam int VALUE_WIDTH = 12;
   localparam int CHAR_WIDTH  = 7;
   localparam int SYM_COUNT   = 13;
   localparam int SYM_WIDTH   = $clog2(SYM_COUNT);

   localparam logic [VALUE_WIDTH-1:0] MAX_VALID = VALUE_WIDTH'(3999);

   localparam logic [CHAR_WIDTH-1:0] CHAR_NONE = 7'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_I    = 7'h49;
   localparam logic [CHAR_WIDTH-1:0] CHAR_V    = 7'h56;
   localparam logic [CHAR_WIDTH-1:0] CHAR_X    = 7'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_L    = 7'h4C;
   localparam logic [CHAR_WIDTH-1:0] CHAR_C    = 7'h43;
   localparam logic [CHAR_WIDTH-1:0] CHAR_D    = 7'h44;
   localparam logic [CHAR_WIDTH-1:0] CHAR_M    = 7'h4D;

   localparam logic [SYM_WIDTH-1:0] SYM_LAST = SYM_WIDTH'(SYM_COUNT - 1);

   typedef enum logic [0:0] {
      ST_IDLE    = 1'b0,
      ST_CONVERT = 1'b1
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic finish_now;
   } status_type;

   function automatic logic [VALUE_WIDTH-1:0] sym_value(input logic [SYM_WIDTH-1:0] k);
      logic [VALUE_WIDTH-1:0] v;
      unique case (k)
         4'd0:    v = VALUE_WIDTH'(1000);
         4'd1:    v = VALUE_WIDTH'(900);
         4'd2:    v = VALUE_WIDTH'(500);
         4'd3:    v = VALUE_WIDTH'(400);
         4'd4:    v = VALUE_WIDTH'(100);
         4'd5:    v = VALUE_WIDTH'(90);
         4'd6:    v = VALUE_WIDTH'(50);
         4'd7:    v = VALUE_WIDTH'(40);
         4'd8:    v = VALUE_WIDTH'(10);
         4'd9:    v = VALUE_WIDTH'(9);
         4'd10:   v = VALUE_WIDTH'(5);
         4'd11:   v = VALUE_WIDTH'(4);
         default: v = VALUE_WIDTH'(1);
      endcase
      return v;
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] sym_first(input logic [SYM_WIDTH-1:0] k);
      logic [CHAR_WIDTH-1:0] c;
      unique case (k)
         4'd0:    c = CHAR_M;
         4'd1:    c = CHAR_C;
         4'd2:    c = CHAR_D;
         4'd3:    c = CHAR_C;
         4'd4:    c = CHAR_C;
         4'd5:    c = CHAR_X;
         4'd6:    c = CHAR_L;
         4'd7:    c = CHAR_X;
         4'd8:    c = CHAR_X;
         4'd9:    c = CHAR_I;
         4'd10:   c = CHAR_V;
         4'd11:   c = CHAR_I;
         default: c = CHAR_I;
      endcase
      return c;
   endfunction

   // second letter of a subtractive pair, none for plain symbols
   function automatic logic [CHAR_WIDTH-1:0] sym_second(input logic [SYM_WIDTH-1:0] k);
      logic [CHAR_WIDTH-1:0] c;
      unique case (k)
         4'd1:    c = CHAR_M;
         4'd3:    c = CHAR_D;
         4'd5:    c = CHAR_C;
         4'd7:    c = CHAR_L;
         4'd9:    c = CHAR_X;
         4'd11:   c = CHAR_V;
         default: c = CHAR_NONE;
      endcase
      return c;
   endfunction

endpackage

// ===== sv/irn_datapath.sv =====
// datapath: remainder, symbol index and result register of the numeral converter
module irn_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [irn_pkg::VALUE_WIDTH-1:0]   req_value,
   input  irn_pkg::cmd_type                  cmd,
   output irn_pkg::status_type               status,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [irn_pkg::CHAR_WIDTH-1:0]    rsp_character,
   output logic                              rsp_last,
   output logic                              rsp_error
);
   import irn_pkg::*;

   logic [VALUE_WIDTH-1:0] rest_ff, rest_in;
   logic [SYM_WIDTH-1:0]   sym_ff, sym_in;
   logic                   pending_ff, pending_in;
   logic                   bad_ff, bad_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  char_ff, char_in;
   logic                   last_ff, last_in;
   logic                   error_ff, error_in;

   logic [VALUE_WIDTH-1:0] sym_val;
   logic [VALUE_WIDTH-1:0] rest_sub;
   logic                   fits;
   logic                   has_second;
   logic                   emit;
   logic                   emit_last;
   logic [CHAR_WIDTH-1:0]  emit_char;

   always_comb begin
      sym_val    = sym_value(sym_ff);
      rest_sub   = rest_ff - sym_val;
      fits       = (rest_ff >= sym_val);
      has_second = (sym_second(sym_ff) != CHAR_NONE);
      emit       = 1'b0;
      emit_last  = 1'b0;
      emit_char  = CHAR_NONE;
      if (pending_ff) begin
         emit      = 1'b1;
         emit_char = sym_second(sym_ff);
         emit_last = (rest_sub == '0);
      end else if (fits) begin
         emit      = 1'b1;
         emit_char = sym_first(sym_ff);
         emit_last = !has_second && (rest_sub == '0);
      end
   end

   always_comb begin
      rest_in    = rest_ff;
      sym_in     = sym_ff;
      pending_in = pending_ff;
      bad_in     = bad_ff;
      if (cmd.load) begin
         rest_in    = req_value;
         sym_in     = '0;
         pending_in = 1'b0;
         bad_in     = (req_value == '0) || (req_value > MAX_VALID);
      end else if (cmd.step && !bad_ff) begin
         if (pending_ff) begin
            rest_in    = rest_sub;
            pending_in = 1'b0;
         end else if (fits) begin
            if (has_second) begin
               pending_in = 1'b1;
            end else begin
               rest_in = rest_sub;
            end
         end else if (sym_ff != SYM_LAST) begin
            sym_in = sym_ff + 1'b1;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      char_in      = char_ff;
      last_in      = last_ff;
      error_in     = error_ff;
      if (cmd.step && (bad_ff || emit)) begin
         rsp_valid_in = 1'b1;
         char_in      = bad_ff ? CHAR_NONE : emit_char;
         last_in      = bad_ff || emit_last;
         error_in     = bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff    <= rest_in;
      sym_ff     <= sym_in;
      pending_ff <= pending_in;
      bad_ff     <= bad_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
      error_ff   <= error_in;
   end

   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.finish_now = bad_ff || (emit && emit_last);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_error     = error_ff;

endmodule

// ===== sv/irn_controller.sv =====
// controller state machine of the numeral converter
module irn_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  irn_pkg::status_type status,
   output irn_pkg::cmd_type    cmd,
   output irn_pkg::state_type  state
);
   import irn_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.finish_now) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign state = state_ff;

endmodule

// ===== sv/integer_to_roman_numeral_unit.sv =====
// top level of the integer to roman numeral unit
// Converts a 12-bit unsigned value into its Roman numeral, emitted as one ASCII
// letter (I V X L C D M) per rsp transaction, most significant letter first, with
// rsp_last on the final letter. Subtractive pairs (IV, IX, XL, XC, CD, CM) come out
// as two consecutive letters. A value of 0 or above 3999 yields one transaction
// with rsp_character 0, rsp_last 1 and rsp_error 1. One value is converted at a
// time: the block takes a req transaction only while idle, loads it, then walks
// greedily over the thirteen symbol values, each step emitting one letter or
// skipping one symbol (at most 12 skips), and holds while the result side
// holds rsp_stall. Each step uses the single subtract-and-compare in the datapath.
module integer_to_roman_numeral_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [irn_pkg::VALUE_WIDTH-1:0]  req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [irn_pkg::CHAR_WIDTH-1:0]   rsp_character,
   output logic                             rsp_last,
   output logic                             rsp_error
);
   import irn_pkg::*;

   cmd_type    cmd;
   status_type status;
   state_type  state;

   // sequencing: idle / convert, drives load and step commands
   irn_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   // remainder, symbol walk and result register
   irn_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .rsp_error     (rsp_error)
   );

   // an accepted transaction closes the input until the numeral is done
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while a conversion is running");

   // error results are single, zero-character and final
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_last && (rsp_character == CHAR_NONE)))
      else $error("malformed error result");

   // good results always carry a letter
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_error) |-> (rsp_character != CHAR_NONE))
      else $error("empty letter in numeral");

   // back in idle the step command stays off
   assert property (@(posedge clock) disable iff (reset)
      (state == ST_IDLE) |-> !cmd.step)
      else $error("step issued while idle");

endmodule
